@@ rtl/cq_pkg.sv @@
// shared types and constants for the circular queue with search
`default_nettype none

package cq_pkg;

  // fixed field widths
  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;
  localparam int SLOT_W = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_MATCH    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISS     = 3'd4;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } state_t;

  // control broadcast to every cell
  typedef struct packed {
    logic shift;  // every cell takes its neighbor's word
    logic load;   // the selected cell takes the incoming word
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/cq_cell.sv @@
// one storage cell of the queue ring
`default_nettype none

module cq_cell (
  input  wire logic                              clk,
  input  wire cq_pkg::cell_ctl_t                 ctl,
  input  wire logic                              sel,
  input  wire logic signed [cq_pkg::WORD_W-1:0]  load_word,
  input  wire logic signed [cq_pkg::WORD_W-1:0]  next_word,
  output logic signed [cq_pkg::WORD_W-1:0]       word
);

  logic signed [cq_pkg::WORD_W-1:0] word_r;

  // rotate from the neighbor, or take a new word when selected
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      word_r <= next_word;
    end else if (ctl.load && sel) begin
      word_r <= load_word;
    end
  end

  assign word = word_r;

endmodule

`default_nettype wire

@@ rtl/circular_queue_with_search.sv @@
// Circular queue of signed words held in a ring of cells, with key search.
// Insert and delete: one result in the cycle after the transaction, next one taken at once.
// Search: busy (queue not empty) while the ring rotates once past cell 0 and in the finish state,
//   one result per match (oldest first) or one empty/not-found result, last flagged.
// Synchronous active-low reset clears pointers, count, sequencer and strobe; stored words
//   are not cleared. The receiver cannot stall results.
`default_nettype none

module circular_queue_with_search #(
  parameter int DEPTH = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [cq_pkg::OP_W-1:0]           in_op,
  input  wire logic signed [cq_pkg::WORD_W-1:0]  in_value,
  output logic                                   out_strobe,
  output logic [cq_pkg::STAT_W-1:0]              out_status,
  output logic signed [cq_pkg::WORD_W-1:0]       out_data_out,
  output logic [cq_pkg::SLOT_W-1:0]              out_slot,
  output logic                                   out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  cq_pkg::state_t state_r, state_nxt;

  logic [PTR_W-1:0]                 head_r, head_nxt;
  logic [CNT_W-1:0]                 occ_r, occ_nxt;
  logic [PTR_W-1:0]                 step_r, step_nxt;
  logic [PTR_W-1:0]                 ptr_r, ptr_nxt;
  logic signed [cq_pkg::WORD_W-1:0] key_r, key_nxt;
  logic                             pend_r, pend_nxt;
  logic [cq_pkg::SLOT_W-1:0]        pend_slot_r, pend_slot_nxt;

  logic                             strobe_r, strobe_nxt;
  logic [cq_pkg::STAT_W-1:0]        status_r, status_nxt;
  logic signed [cq_pkg::WORD_W-1:0] data_r, data_nxt;
  logic [cq_pkg::SLOT_W-1:0]        slot_r, slot_nxt;
  logic                             last_r, last_nxt;

  cq_pkg::cell_ctl_t                ctl;
  logic signed [cq_pkg::WORD_W-1:0] cell_word [DEPTH];
  logic                             accept;
  logic                             hit;
  logic [PTR_W-1:0]                 ptr_inc;
  logic [PTR_W-1:0]                 head_inc;

  assign accept   = start && (state_r == cq_pkg::S_IDLE);
  assign busy     = (state_r != cq_pkg::S_IDLE);
  assign ptr_inc  = (ptr_r == PTR_MAX) ? '0 : ptr_r + 1'b1;
  assign head_inc = (head_r == PTR_MAX) ? '0 : head_r + 1'b1;
  // probe at cell 0 sees logical entry step_r during the rotation
  assign hit      = (CNT_W'(step_r) < occ_r) && (cell_word[0] == key_r);

  // ring of cells, each fed by its upper neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .sel       (occ_r == CNT_W'(i)),
      .load_word (in_value),
      .next_word (cell_word[(i + 1) % DEPTH]),
      .word      (cell_word[i])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cq_pkg::S_IDLE: begin
        if (accept && in_op == cq_pkg::OP_SEARCH && occ_r != '0) begin
          state_nxt = cq_pkg::S_SEARCH;
        end
      end
      cq_pkg::S_SEARCH: begin
        if (step_r == PTR_MAX) begin
          state_nxt = cq_pkg::S_FINISH;
        end
      end
      cq_pkg::S_FINISH: state_nxt = cq_pkg::S_IDLE;
      default:          state_nxt = cq_pkg::S_IDLE;
    endcase
  end

  // datapath control and result generation
  always_comb begin
    ctl           = '0;
    head_nxt      = head_r;
    occ_nxt       = occ_r;
    step_nxt      = step_r;
    ptr_nxt       = ptr_r;
    key_nxt       = key_r;
    pend_nxt      = pend_r;
    pend_slot_nxt = pend_slot_r;
    strobe_nxt    = 1'b0;
    status_nxt    = cq_pkg::ST_OK;
    data_nxt      = '0;
    slot_nxt      = '0;
    last_nxt      = 1'b1;
    case (state_r)
      cq_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            cq_pkg::OP_INSERT: begin
              strobe_nxt = 1'b1;
              if (occ_r == CNT_FULL) begin
                status_nxt = cq_pkg::ST_OVERFLOW;
              end else begin
                ctl.load = 1'b1;
                occ_nxt  = occ_r + 1'b1;
              end
            end
            cq_pkg::OP_DELETE: begin
              strobe_nxt = 1'b1;
              if (occ_r == '0) begin
                status_nxt = cq_pkg::ST_EMPTY;
              end else begin
                // oldest word leaves cell 0, the rest move down
                data_nxt  = cell_word[0];
                ctl.shift = 1'b1;
                occ_nxt   = occ_r - 1'b1;
                head_nxt  = (occ_r == CNT_W'(1)) ? '0 : head_inc;
              end
            end
            cq_pkg::OP_SEARCH: begin
              if (occ_r == '0) begin
                strobe_nxt = 1'b1;
                status_nxt = cq_pkg::ST_EMPTY;
              end else begin
                key_nxt  = in_value;
                step_nxt = '0;
                ptr_nxt  = head_r;
                pend_nxt = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      cq_pkg::S_SEARCH: begin
        // one full rotation brings the ring back to where it started
        ctl.shift = 1'b1;
        ptr_nxt   = ptr_inc;
        step_nxt  = step_r + 1'b1;
        if (hit) begin
          // a newer match means the held one is not the last
          if (pend_r) begin
            strobe_nxt = 1'b1;
            status_nxt = cq_pkg::ST_MATCH;
            slot_nxt   = pend_slot_r;
            last_nxt   = 1'b0;
          end
          pend_nxt      = 1'b1;
          pend_slot_nxt = cq_pkg::SLOT_W'(ptr_r) + 1'b1;
        end
      end
      cq_pkg::S_FINISH: begin
        strobe_nxt = 1'b1;
        if (pend_r) begin
          status_nxt = cq_pkg::ST_MATCH;
          slot_nxt   = pend_slot_r;
        end else begin
          status_nxt = cq_pkg::ST_MISS;
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= cq_pkg::S_IDLE;
      head_r   <= '0;
      occ_r    <= '0;
      step_r   <= '0;
      ptr_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      occ_r    <= occ_nxt;
      step_r   <= step_nxt;
      ptr_r    <= ptr_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    pend_slot_r <= pend_slot_nxt;
    status_r    <= status_nxt;
    data_r      <= data_nxt;
    slot_r      <= slot_nxt;
    last_r      <= last_nxt;
  end

  assign out_strobe   = strobe_r;
  assign out_status   = status_r;
  assign out_data_out = data_r;
  assign out_slot     = slot_r;
  assign out_last     = last_r;

endmodule

`default_nettype wire

@@ rtl/cq_checker.sv @@
// port-level checks for the circular queue, bound to the top level
`default_nettype none

module cq_checker #(
  parameter int DEPTH = 8
) (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic [cq_pkg::OP_W-1:0]           in_op,
  input wire logic                              out_strobe,
  input wire logic [cq_pkg::STAT_W-1:0]         out_status,
  input wire logic signed [cq_pkg::WORD_W-1:0]  out_data_out,
  input wire logic [cq_pkg::SLOT_W-1:0]         out_slot,
  input wire logic                              out_last
);

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_strobe)
    else $error("block not idle after reset");

  // insert and delete give exactly one final result in the next cycle
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == cq_pkg::OP_INSERT || in_op == cq_pkg::OP_DELETE))
    |=> out_strobe && out_last)
    else $error("insert or delete transaction without a single final result");

  // a match carries a slot in range and no data
  a_match_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status == cq_pkg::ST_MATCH)
    |-> out_slot != '0 && out_slot <= cq_pkg::SLOT_W'(DEPTH) && out_data_out == '0)
    else $error("match result with bad slot or data");

  // only match results may be followed by more results
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_status != cq_pkg::ST_MATCH) |-> out_last && out_slot == '0)
    else $error("non-match result not final");

endmodule

bind circular_queue_with_search cq_checker #(.DEPTH(DEPTH)) u_cq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_op        (in_op),
  .out_strobe   (out_strobe),
  .out_status   (out_status),
  .out_data_out (out_data_out),
  .out_slot     (out_slot),
  .out_last     (out_last)
);

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the circular queue with search: directed cases, then random traffic
module tb_top;

  localparam int DEPTH = 8;
  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [cq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  // cycles with no transaction at all before the run is declared hung
  localparam int STALL_LIMIT = 300;
  // settle time after the last expected result
  localparam int DRAIN_CYCLES = 2 * DEPTH + 4;
  localparam int WORD_POOL_N = 6;
  localparam logic signed [cq_pkg::WORD_W-1:0] WORD_POOL [WORD_POOL_N] = '{
    32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000,
    32'shffff_ffff, 32'sh0000_0001, 32'sh5a5a_5a5a
  };

  typedef struct {
    logic [cq_pkg::STAT_W-1:0]        status;
    logic signed [cq_pkg::WORD_W-1:0] data;
    logic [cq_pkg::SLOT_W-1:0]        slot;
    logic                             last;
  } queue_result_t;

  logic                             clk;
  logic                             rst_n    = 1'b0;
  logic                             start    = 1'b0;
  logic [cq_pkg::OP_W-1:0]          in_op    = cq_pkg::OP_INSERT;
  logic signed [cq_pkg::WORD_W-1:0] in_value = '0;
  logic                             busy;
  logic                             out_strobe;
  logic [cq_pkg::STAT_W-1:0]        out_status;
  logic signed [cq_pkg::WORD_W-1:0] out_data_out;
  logic [cq_pkg::SLOT_W-1:0]        out_slot;
  logic                             out_last;

  // shadow copy of the queue contents
  logic signed [cq_pkg::WORD_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]                 ring_head;
  logic [PTR_W-1:0]                 ring_tail;
  logic [PTR_W:0]                   ring_count;
  queue_result_t                    expected_results [$];

  int  mismatch_count = 0;
  int  idle_cycles    = 0;
  bit  gaps_on        = 1'b1;
  int  n_insert = 0, n_overflow = 0, n_delete = 0, n_underflow = 0;
  int  n_search = 0, n_match = 0, n_miss = 0, n_search_empty = 0, n_ignored = 0;

  circular_queue_with_search #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_value    (in_value),
    .out_strobe  (out_strobe),
    .out_status  (out_status),
    .out_data_out(out_data_out),
    .out_slot    (out_slot),
    .out_last    (out_last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected results of one accepted transaction, queue state updated
  task automatic predict_op(input logic [cq_pkg::OP_W-1:0] op,
                            input logic signed [cq_pkg::WORD_W-1:0] value);
    queue_result_t    r;
    logic [PTR_W-1:0] idx;
    int               hits;
    int               seen;
    int               n;
    r = '{status: cq_pkg::ST_OK, data: '0, slot: '0, last: 1'b1};
    case (op)
      cq_pkg::OP_INSERT: begin
        n_insert++;
        if (ring_count == DEPTH) begin
          r.status = cq_pkg::ST_OVERFLOW;
          n_overflow++;
        end else begin
          ring_mem[ring_tail] = value;
          ring_tail = PTR_W'((ring_tail + 1) % DEPTH);
          ring_count++;
        end
        expected_results.push_back(r);
      end
      cq_pkg::OP_DELETE: begin
        n_delete++;
        if (ring_count == 0) begin
          r.status = cq_pkg::ST_EMPTY;
          n_underflow++;
        end else begin
          r.data = ring_mem[ring_head];
          ring_count--;
          // an emptied queue restarts at slot 0
          if (ring_count == 0) begin
            ring_head = '0;
            ring_tail = '0;
          end else begin
            ring_head = PTR_W'((ring_head + 1) % DEPTH);
          end
        end
        expected_results.push_back(r);
      end
      cq_pkg::OP_SEARCH: begin
        n_search++;
        if (ring_count == 0) begin
          r.status = cq_pkg::ST_EMPTY;
          n_search_empty++;
          expected_results.push_back(r);
        end else begin
          // first pass counts matches so the final one can carry last
          hits = 0;
          idx  = ring_head;
          for (n = 0; n < ring_count; n++) begin
            if (ring_mem[idx] == value) hits++;
            idx = PTR_W'((idx + 1) % DEPTH);
          end
          if (hits == 0) begin
            r.status = cq_pkg::ST_MISS;
            n_miss++;
            expected_results.push_back(r);
          end else begin
            seen = 0;
            idx  = ring_head;
            for (n = 0; n < ring_count; n++) begin
              if (ring_mem[idx] == value) begin
                seen++;
                r.status = cq_pkg::ST_MATCH;
                r.slot   = cq_pkg::SLOT_W'(idx) + 1'b1;
                r.last   = (seen == hits);
                expected_results.push_back(r);
              end
              idx = PTR_W'((idx + 1) % DEPTH);
            end
            n_match += hits;
          end
        end
      end
      default: n_ignored++;  // unused code: no result, no state change
    endcase
  endtask

  // drive one transaction and wait until the block takes it; start stays high on return
  task automatic send_cmd(input logic [cq_pkg::OP_W-1:0] op,
                          input logic signed [cq_pkg::WORD_W-1:0] value);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(99) < 35) gap = $urandom_range(1, 5);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_op(op, value);
  endtask

  // random word: duplicates from a small pool, stored words for keys, or anything
  function automatic logic signed [cq_pkg::WORD_W-1:0] pick_word(input bit prefer_stored);
    int roll;
    roll = $urandom_range(99);
    if (prefer_stored && ring_count != 0 && roll < 55)
      return ring_mem[PTR_W'((int'(ring_head) + $urandom_range(int'(ring_count) - 1))
                             % DEPTH)];
    if (roll < 75) return WORD_POOL[$urandom_range(WORD_POOL_N - 1)];
    return $urandom;
  endfunction

  // result checker: every strobe is matched against the oldest expectation
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d data=%0d slot=%0d last=%0b",
                 $time, out_status, out_data_out, out_slot, out_last);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, out_status);
          mismatch_count++;
        end
        if (out_data_out !== exp_r.data) begin
          $display("%0t: data_out expected %0d got %0d", $time, exp_r.data, out_data_out);
          mismatch_count++;
        end
        if (out_slot !== exp_r.slot) begin
          $display("%0t: slot expected %0d got %0d", $time, exp_r.slot, out_slot);
          mismatch_count++;
        end
        if (out_last !== exp_r.last) begin
          $display("%0t: last expected %0b got %0b", $time, exp_r.last, out_last);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: cycles with neither a command nor a result transaction
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, expected_results.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // operations on an empty queue, and the unused code
  task automatic test_empty_queue();
    send_cmd(cq_pkg::OP_SEARCH, 32'sh0);
    send_cmd(cq_pkg::OP_DELETE, 32'sh0);
    send_cmd(OP_UNUSED, 32'shffff_ffff);
  endtask

  // fill to the brim with extreme and repeated words, then one insert too many
  task automatic test_fill_and_overflow();
    send_cmd(cq_pkg::OP_INSERT, 32'sh8000_0000);
    send_cmd(cq_pkg::OP_INSERT, 32'sh7fff_ffff);
    send_cmd(cq_pkg::OP_INSERT, 32'sh0);
    send_cmd(cq_pkg::OP_INSERT, -32'sd1);
    send_cmd(cq_pkg::OP_INSERT, -32'sd1);
    send_cmd(cq_pkg::OP_INSERT, 32'sh1);
    send_cmd(cq_pkg::OP_INSERT, 32'sh5a5a_5a5a);
    send_cmd(cq_pkg::OP_INSERT, -32'sd1);
    send_cmd(cq_pkg::OP_INSERT, 32'sh7);
  endtask

  // several matches, no match, single match at the first slot
  task automatic test_search_cases();
    send_cmd(cq_pkg::OP_SEARCH, -32'sd1);
    send_cmd(cq_pkg::OP_SEARCH, 32'sd12345);
    send_cmd(cq_pkg::OP_SEARCH, 32'sh8000_0000);
  endtask

  // drain to empty, then the next word must land in slot 1
  task automatic test_drain_and_restart();
    repeat (DEPTH) send_cmd(cq_pkg::OP_DELETE, $urandom);
    send_cmd(cq_pkg::OP_INSERT, 32'sd42);
    send_cmd(cq_pkg::OP_SEARCH, 32'sd42);
  endtask

  // random mix in phases, each phase picked at random to favour filling or draining
  task automatic test_random_traffic(input int n_items, input bit with_gaps);
    int done;
    int roll;
    int fill_bias;
    int phase_left;
    gaps_on    = with_gaps;
    done       = 0;
    phase_left = 0;
    fill_bias  = 50;
    while (done < n_items) begin
      if (phase_left == 0) begin
        fill_bias  = $urandom_range(1) ? 60 : 25;
        phase_left = $urandom_range(10, 25);
      end
      roll = $urandom_range(99);
      if (roll < 3) begin
        send_cmd(OP_UNUSED, $urandom);
      end else begin
        if (roll < 3 + fill_bias)
          send_cmd(cq_pkg::OP_INSERT, pick_word(1'b0));
        else if (roll < 3 + fill_bias + (97 - fill_bias) / 2)
          send_cmd(cq_pkg::OP_DELETE, $urandom);
        else
          send_cmd(cq_pkg::OP_SEARCH, pick_word(1'b1));
        done++;
        phase_left--;
      end
    end
  endtask

  // main sequence
  initial begin
    ring_head  = '0;
    ring_tail  = '0;
    ring_count = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queue();
    test_fill_and_overflow();
    test_search_cases();
    test_drain_and_restart();
    test_random_traffic(140, 1'b1);
    test_random_traffic(120, 1'b0);

    // let the last results come out
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d inserts (%0d overflow), %0d deletes (%0d underflow), %0d ignored",
             n_insert, n_overflow, n_delete, n_underflow, n_ignored);
    $display("covered %0d searches: %0d matches, %0d misses, %0d on an empty queue",
             n_search, n_match, n_miss, n_search_empty);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
